>>> src/vss_pkg.sv
// shared types, constants and glyph lookup for the seven-segment voltmeter scan block
// no dependencies; imported by every module of the block
package vss_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int CENTI_W   = 10;
  localparam int SCALED_W  = 18;   // reading * full scale + rounding offset
  localparam int RECIP_W   = 19;
  localparam int RECIP_SH  = 26;
  localparam int PROD_W    = SCALED_W + RECIP_W;
  localparam int SEG_W     = 8;
  localparam int POS_W     = 2;
  localparam int EN_W      = 4;

  localparam logic [CENTI_W-1:0]  FULL_SCALE_RESET = 10'd330;
  localparam logic [SCALED_W-1:0] ROUND_OFS        = 18'd127;  // half of 255, rounded down
  // ceil(2^26 / 255): exact floor division by 255 for every scaled value in range
  localparam logic [RECIP_W-1:0]  RECIP_255        = 19'd263173;
  localparam logic [CENTI_W:0]    MAX_CENTI        = 11'd999;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [POS_W-1:0] POS_UNITS      = 2'd0;
  localparam logic [POS_W-1:0] POS_TENTHS     = 2'd1;
  localparam logic [POS_W-1:0] POS_HUNDREDTHS = 2'd2;
  localparam logic [POS_W-1:0] POS_BLANK      = 2'd3;

  localparam logic [SEG_W-1:0] SEG_DASH  = 8'hBF;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

  typedef struct packed {
    logic                kind;
    logic [SCALED_W-1:0] scaled;
  } mid_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;
  } res_t;

  // active-low glyphs, bit 0 is segment a
  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

>>> src/vss_front.sv
// front end: input acceptance, full-scale register, reading multiply and two-entry queue
// depends on vss_pkg
module vss_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_kind,
  input  logic [vss_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vss_pkg::CENTI_W-1:0]   cfg_full_scale_centivolts,
  output logic                          q_valid,
  output vss_pkg::mid_t                 q_head,
  input  logic                          q_pop
);
  import vss_pkg::*;

  logic [CENTI_W-1:0]  fs_r;
  mid_t                entry_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push_ok, pop_ok;
  logic [SCALED_W-1:0] prod;
  mid_t                new_entry;

  assign cfg_ready = 1'b1;
  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop_ok    = q_pop && q_valid;
  assign q_head    = entry_r[rd_ptr_r];

  // reading times full scale plus the rounding offset, registered into the queue
  assign prod             = SCALED_W'(in_sample) * SCALED_W'(fs_r);
  assign new_entry.kind   = in_kind;
  assign new_entry.scaled = prod + ROUND_OFS;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r     <= FULL_SCALE_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fs_r <= cfg_full_scale_centivolts;
      end
      if (push_ok) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

>>> src/vss_back.sv
// back end: divide by full code, held value, scan position, digit decode and result queue
// depends on vss_pkg
module vss_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  vss_pkg::mid_t              q_head,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [vss_pkg::SEG_W-1:0]  out_segments,
  output logic [vss_pkg::EN_W-1:0]   out_digit_enable
);
  import vss_pkg::*;

  logic [CENTI_W-1:0] held_r, held_nxt;
  logic               valid_r;
  logic [POS_W-1:0]   pos_r;
  res_t               res_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         ocnt_r, ocnt_nxt;
  logic               do_sample, do_tick, opop_ok;
  logic [PROD_W-1:0]  quot_prod;
  logic [CENTI_W:0]   quot;
  logic [15:0]        h_prod;
  logic [3:0]         d_hund;
  logic [6:0]         rem_hund;
  logic [14:0]        t_prod;
  logic [3:0]         d_ten;
  logic [3:0]         d_unit;
  res_t               new_res;

  assign q_pop     = q_valid && (q_head.kind == KIND_SAMPLE || ocnt_r != 2'd2);
  assign do_sample = q_pop && (q_head.kind == KIND_SAMPLE);
  assign do_tick   = q_pop && (q_head.kind == KIND_TICK);

  // floor division by 255 through the reciprocal, then saturate
  assign quot_prod = PROD_W'(q_head.scaled) * PROD_W'(RECIP_255);
  assign quot      = quot_prod[RECIP_SH +: CENTI_W+1];
  assign held_nxt  = (quot > MAX_CENTI) ? CENTI_W'(MAX_CENTI) : quot[CENTI_W-1:0];

  // digit split of the held value, exact for values up to 999
  assign h_prod   = 16'(held_r) * 16'd41;
  assign d_hund   = h_prod[15:12];
  assign rem_hund = 7'(held_r - 10'(d_hund) * 10'd100);
  assign t_prod   = 15'(rem_hund) * 15'd205;
  assign d_ten    = t_prod[14:11];
  assign d_unit   = 4'(rem_hund - 7'(d_ten) * 7'd10);

  always_comb begin
    if (!valid_r) begin
      new_res.segments = SEG_DASH;
    end else begin
      unique case (pos_r)
        POS_UNITS:      new_res.segments = glyph(d_hund) & ~SEG_POINT;
        POS_TENTHS:     new_res.segments = glyph(d_ten);
        POS_HUNDREDTHS: new_res.segments = glyph(d_unit);
        POS_BLANK:      new_res.segments = SEG_BLANK;
        default:        new_res.segments = SEG_BLANK;
      endcase
    end
    new_res.digit_enable = EN_W'(1) << pos_r;
  end

  assign out_empty        = (ocnt_r == 2'd0);
  assign opop_ok          = out_pop && !out_empty;
  assign out_segments     = res_r[rd_ptr_r].segments;
  assign out_digit_enable = res_r[rd_ptr_r].digit_enable;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (do_tick && !opop_ok) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (opop_ok && !do_tick) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      valid_r  <= 1'b0;
      pos_r    <= POS_UNITS;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      ocnt_r   <= 2'd0;
    end else begin
      if (do_sample) begin
        held_r  <= held_nxt;
        valid_r <= 1'b1;
      end
      if (do_tick) begin
        pos_r    <= pos_r + 2'd1;
        wr_ptr_r <= !wr_ptr_r;
      end
      if (opop_ok) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      res_r[wr_ptr_r] <= new_res;
    end
  end

endmodule

>>> src/voltmeter_seven_segment_scan_top.sv
// path: a tick is registered in the front queue, then decoded into the result queue when that has
//   room and reaches the result ports at the queue head; a sample updates the value for any later tick
// throughput: one transaction per cycle while results drain; divide and digit decode are combinational
// reset: synchronous active-low rst_n; full scale returns to 3.30 V, queues empty,
//   scan position 0, and every position shows a dash until the first sample
// depends on vss_pkg, vss_front, vss_back
module voltmeter_seven_segment_scan_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input queue side
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_kind,
  input  logic [vss_pkg::SAMPLE_W-1:0]  in_sample,
  // result queue side
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [vss_pkg::SEG_W-1:0]     out_segments,
  output logic [vss_pkg::EN_W-1:0]      out_digit_enable,
  // full-scale register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vss_pkg::CENTI_W-1:0]   cfg_full_scale_centivolts
);
  import vss_pkg::*;

  // front to back queue head
  logic q_valid;
  logic q_pop;
  mid_t q_head;

  // front: takes transactions of both kinds while its queue has room, multiplies the reading by full
  // scale in the accepting cycle and parks the product in a two-entry queue in order
  vss_front u_front (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_push                   (in_push),
    .in_full                   (in_full),
    .in_kind                   (in_kind),
    .in_sample                 (in_sample),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_full_scale_centivolts (cfg_full_scale_centivolts),
    .q_valid                   (q_valid),
    .q_head                    (q_head),
    .q_pop                     (q_pop)
  );

  // back: samples divide by 255, rounded by the offset added in front, and saturate into the held value;
  // ticks decode the current position into the result queue and advance the scan
  vss_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_segments     (out_segments),
    .out_digit_enable (out_digit_enable)
  );

endmodule

>>> bench/tb_voltmeter_seven_segment_scan_top.sv
// testbench for the seven-segment voltmeter scan block: directed and random transactions
// with an own predictor of the display, checked result by result at the result queue
// depends on vss_pkg and voltmeter_seven_segment_scan_top
module tb_voltmeter_seven_segment_scan_top;
  import vss_pkg::*;

  localparam int CYCLE_LIMIT      = 600000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int RANDOM_PER_PHASE = 206;
  localparam int FULL_CODE        = 255;    // largest 8-bit converter reading
  localparam int TOP_CENTI        = 999;
  localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic                in_kind;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_empty;
  logic                out_pop;
  logic [SEG_W-1:0]    out_segments;
  logic [EN_W-1:0]     out_digit_enable;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CENTI_W-1:0]  cfg_full_scale_centivolts;

  // predictor state: mirrors the block's register, held value and scan position
  logic [CENTI_W-1:0]  full_scale_now;
  logic [CENTI_W-1:0]  shown_centivolts;
  bit                  have_reading;
  logic [POS_W-1:0]    scan_pos_now;

  // one expected scan step per accepted tick, oldest first
  res_t                pending_digits [$];
  res_t                oldest_digit;

  int                  errors;
  int                  ticks_checked;
  int                  samples_sent;
  int                  settings_used;
  int                  cycle_count;

  // idling controls for the stimulus and the result drain
  bit                  tx_gaps_on;
  bit                  rx_stalls_on;
  int                  pop_hold_left;
  int                  pop_roll;

  voltmeter_seven_segment_scan_top DUT (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_push                   (in_push),
    .in_full                   (in_full),
    .in_kind                   (in_kind),
    .in_sample                 (in_sample),
    .out_empty                 (out_empty),
    .out_pop                   (out_pop),
    .out_segments              (out_segments),
    .out_digit_enable          (out_digit_enable),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_full_scale_centivolts (cfg_full_scale_centivolts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the block hangs or loses a transaction
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("voltmeter_seven_segment_scan_top verification failed");
      $finish;
    end
  end

  // reading scaled to hundredths of a volt, rounded to nearest, clamped at 9.99
  function automatic logic [CENTI_W-1:0] to_centivolts(input logic [SAMPLE_W-1:0] reading,
                                                       input logic [CENTI_W-1:0] full_scale);
    int unsigned prod;
    int unsigned quot;
    prod = 32'(reading) * 32'(full_scale);
    quot = (2 * prod + FULL_CODE) / (2 * FULL_CODE);
    if (quot > TOP_CENTI) quot = TOP_CENTI;
    return quot[CENTI_W-1:0];
  endfunction

  // what the display drives for one scan position given the held value
  function automatic res_t scan_step_for(input logic [POS_W-1:0] pos);
    res_t step;
    int   v;
    v = shown_centivolts;
    step.digit_enable = EN_W'(1) << pos;
    if (!have_reading) begin
      step.segments = SEG_DASH;
    end else begin
      case (pos)
        POS_UNITS:      step.segments = DIGIT_GLYPH[(v / 100) % 10] & ~SEG_POINT;
        POS_TENTHS:     step.segments = DIGIT_GLYPH[(v / 10) % 10];
        POS_HUNDREDTHS: step.segments = DIGIT_GLYPH[v % 10];
        default:        step.segments = SEG_BLANK;
      endcase
    end
    return step;
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // converter reading with the ends of the range favored
  function automatic logic [SAMPLE_W-1:0] pick_reading();
    logic [SAMPLE_W-1:0] ends [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(0, 99) < 10) return ends[$urandom_range(0, 3)];
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // result drain: pop changes at the falling edge, stalls of random length
  initial begin
    out_pop       = 1'b0;
    pop_hold_left = 0;
    forever begin
      @(negedge clk);
      if (pop_hold_left == 0 && rx_stalls_on) begin
        pop_roll = $urandom_range(0, 99);
        if (pop_roll < 20) pop_hold_left = $urandom_range(1, 3);
        else if (pop_roll < 23) pop_hold_left = $urandom_range(10, 40);
      end
      if (pop_hold_left > 0) begin
        out_pop = 1'b0;
        pop_hold_left--;
      end else begin
        out_pop = 1'b1;
      end
    end
  end

  // result check: every popped transaction against the oldest expected scan step
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_digits.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got segments %h enable %h",
                 $time, out_segments, out_digit_enable);
      end else begin
        oldest_digit = pending_digits.pop_front();
        ticks_checked++;
        if (out_segments !== oldest_digit.segments) begin
          errors++;
          $display("%0t segments mismatch: expected %h, actual %h",
                   $time, oldest_digit.segments, out_segments);
        end
        if (out_digit_enable !== oldest_digit.digit_enable) begin
          errors++;
          $display("%0t digit_enable mismatch: expected %h, actual %h",
                   $time, oldest_digit.digit_enable, out_digit_enable);
        end
      end
    end
  end

  // one input transaction; the predictor advances at the accepting edge
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] reading);
    int gap;
    @(negedge clk);
    in_push   = 1'b1;
    in_kind   = kind;
    in_sample = reading;
    do @(posedge clk); while (in_full);
    if (kind == KIND_SAMPLE) begin
      shown_centivolts = to_centivolts(reading, full_scale_now);
      have_reading     = 1'b1;
      samples_sent++;
    end else begin
      pending_digits.push_back(scan_step_for(scan_pos_now));
      scan_pos_now = scan_pos_now + 1'b1;
    end
    // a zero gap leaves push high for a back-to-back transaction
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(KIND_TICK, pick_reading());
  endtask

  // stop sending, let every expected result come out, then cover the pipeline depth
  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full-scale register write, only with the block idle
  task automatic write_full_scale(input logic [CENTI_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid                 = 1'b1;
    cfg_full_scale_centivolts = value;
    do @(posedge clk); while (!cfg_ready);
    full_scale_now = value;
    settings_used++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // no sample yet: every position including the blank one shows a dash
  task automatic test_dashes_before_reading();
    send_ticks(5);
  endtask

  // top reading at the reset full scale reads 3.30, then zero reads 0.00
  task automatic test_full_scale_reading();
    send_item(KIND_SAMPLE, 8'd255);
    send_ticks(4);
    send_item(KIND_SAMPLE, 8'd0);
    send_ticks(2);
  endtask

  // full scale above 9.99 clamps the held value
  task automatic test_saturation_at_top();
    write_full_scale(10'd1023);
    send_item(KIND_SAMPLE, 8'd255);
    send_ticks(4);
  endtask

  // zero full scale turns any reading into 0.00
  task automatic test_zero_full_scale();
    write_full_scale(10'd0);
    send_item(KIND_SAMPLE, 8'd200);
    send_ticks(2);
  endtask

  // one hundredth full scale: rounding picks between 0.00 and 0.01 around mid code
  task automatic test_finest_step();
    write_full_scale(10'd1);
    send_item(KIND_SAMPLE, 8'd128);
    send_ticks(1);
    send_item(KIND_SAMPLE, 8'd127);
    send_ticks(1);
  endtask

  // random samples and ticks under one full-scale setting
  task automatic run_random_phase(input logic [CENTI_W-1:0] full_scale, input bit quiet,
                                  input bit pause_midway);
    logic kind;
    write_full_scale(full_scale);
    tx_gaps_on   = !quiet;
    rx_stalls_on = !quiet;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      kind = ($urandom_range(0, 99) < 25) ? KIND_SAMPLE : KIND_TICK;
      send_item(kind, pick_reading());
      // hold the sender until the result queue has fully drained
      if (pause_midway && i == RANDOM_PER_PHASE / 2) settle();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_random_settings();
    run_random_phase(FULL_SCALE_RESET, 1'b0, 1'b0);
    run_random_phase(10'd1, 1'b0, 1'b0);
    run_random_phase(10'd999, 1'b1, 1'b0);   // no idling on either side
    run_random_phase(10'd1023, 1'b0, 1'b0);
    run_random_phase(10'd0, 1'b0, 1'b1);
    run_random_phase(CENTI_W'($urandom_range(1, 999)), 1'b0, 1'b0);
    run_random_phase(CENTI_W'($urandom_range(1, 999)), 1'b1, 1'b0);
    run_random_phase(CENTI_W'($urandom_range(0, 1023)), 1'b0, 1'b0);
  endtask

  initial begin
    // every input known from time zero while reset is held
    rst_n                     = 1'b0;
    in_push                   = 1'b0;
    in_kind                   = KIND_TICK;
    in_sample                 = '0;
    cfg_valid                 = 1'b0;
    cfg_full_scale_centivolts = FULL_SCALE_RESET;
    tx_gaps_on                = 1'b1;
    rx_stalls_on              = 1'b1;
    errors                    = 0;
    ticks_checked             = 0;
    samples_sent              = 0;
    settings_used             = 0;
    cycle_count               = 0;
    full_scale_now            = FULL_SCALE_RESET;
    shown_centivolts          = '0;
    have_reading              = 1'b0;
    scan_pos_now              = POS_UNITS;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_dashes_before_reading();
    test_full_scale_reading();
    test_saturation_at_top();
    test_zero_full_scale();
    test_finest_step();
    test_random_settings();

    settle();
    $display("covered %0d scan steps checked, %0d readings, %0d full-scale settings",
             ticks_checked, samples_sent, settings_used);
    $display("dashes before first reading, clamping, zero and one-hundredth full scale");
    if (errors == 0) begin
      $display("voltmeter_seven_segment_scan_top verification clean");
    end else begin
      $display("voltmeter_seven_segment_scan_top verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/vss_pkg.sv
src/vss_front.sv
src/vss_back.sv
src/voltmeter_seven_segment_scan_top.sv
bench/tb_voltmeter_seven_segment_scan_top.sv
